// ----- rtl/lruc_pkg.sv -----
// package for the lru lookup-or-insert cache
// field widths, default sizes and the result record; no dependencies
package lruc_pkg;

   localparam int KEY_W        = 64;   // width of the key field on the request channel
   localparam int SLOT_W       = 7;    // width of the reported slot
   localparam int OCC_W        = 8;    // width of the reported occupancy
   localparam int DEF_ENTRIES  = 128;
   localparam int DEF_KEY_BITS = 64;

   typedef struct packed {
      logic              was_hit;
      logic [SLOT_W-1:0] slot_index;
      logic              evicted_old;
      logic [OCC_W-1:0]  occupied_count;
   } result_type;

endpackage

// ----- rtl/lruc_if.sv -----
// request and response channel interfaces of the lru cache
// depends on lruc_pkg for the field widths
interface lruc_req_if import lruc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [KEY_W-1:0] lookup_key;

   modport source (output valid, output lookup_key, input ready);
   modport sink   (input valid, input lookup_key, output ready);
endinterface

interface lruc_rsp_if import lruc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              was_hit;
   logic [SLOT_W-1:0] slot_index;
   logic              evicted_old;
   logic [OCC_W-1:0]  occupied_count;

   modport source (output valid, output was_hit, output slot_index, output evicted_old,
                   output occupied_count, input ready);
   modport sink   (input valid, input was_hit, input slot_index, input evicted_old,
                   input occupied_count, output ready);
endinterface

// ----- rtl/lruc_ram.sv -----
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module lruc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/lruc_engine.sv -----
// scan and update sequencer of the lru cache, holds the key and age memories
// depends on lruc_pkg and lruc_ram
module lruc_engine import lruc_pkg::*; #(
   parameter int ENTRIES  = DEF_ENTRIES,
   parameter int KEY_BITS = DEF_KEY_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [KEY_BITS-1:0] start_key,
   input  logic                out_ready,
   output logic                idle,
   output logic                done,
   output result_type          result
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int AGE_W = IDX_W;
   localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(ENTRIES - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ENTRIES);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]    rd_tag_ff, rd_tag_in;
   logic                hit_ff, hit_in;
   logic                evict_ff, evict_in;
   logic [IDX_W-1:0]    slot_ff, slot_in;
   logic [IDX_W-1:0]    victim_ff, victim_in;
   logic [AGE_W-1:0]    hit_age_ff, hit_age_in;

   logic                rd_en;
   logic [IDX_W-1:0]    rd_addr;
   logic [KEY_BITS-1:0] key_rd;
   logic [AGE_W-1:0]    age_rd;
   logic                key_wr_en;
   logic                age_wr_en;
   logic [IDX_W-1:0]    age_wr_addr;
   logic [AGE_W-1:0]    age_wr_data;
   logic                issue;
   logic                full;
   logic [CNT_W-1:0]    count_next;

   lruc_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (slot_ff),
      .wr_data (key_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (key_rd)
   );

   lruc_ram #(.WIDTH(AGE_W), .DEPTH(ENTRIES)) u_age_ram (
      .clock   (clock),
      .wr_en   (age_wr_en),
      .wr_addr (age_wr_addr),
      .wr_data (age_wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (age_rd)
   );

   // valid entries are always slots 0 .. count-1
   assign rd_addr    = rd_idx_ff[IDX_W-1:0];
   assign issue      = (rd_idx_ff != count_ff);
   assign full       = (count_ff == CNT_FULL);
   assign count_next = (hit_ff || full) ? count_ff : count_ff + 1'b1;

   always_comb begin
      state_in    = state_ff;
      key_in      = key_ff;
      count_in    = count_ff;
      rd_idx_in   = rd_idx_ff;
      rd_vld_in   = 1'b0;
      rd_tag_in   = rd_tag_ff;
      hit_in      = hit_ff;
      evict_in    = evict_ff;
      slot_in     = slot_ff;
      victim_in   = victim_ff;
      hit_age_in  = hit_age_ff;
      rd_en       = 1'b0;
      key_wr_en   = 1'b0;
      age_wr_en   = 1'b0;
      age_wr_addr = rd_tag_ff;
      age_wr_data = '0;
      done        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               key_in     = start_key;
               hit_in     = 1'b0;
               victim_in  = '0;
               hit_age_in = '0;
               rd_idx_in  = '0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue) begin
               rd_en     = 1'b1;
               rd_idx_in = rd_idx_ff + 1'b1;
               rd_vld_in = 1'b1;
               rd_tag_in = rd_addr;
            end
            if (rd_vld_ff) begin
               if (!hit_ff && key_rd == key_ff) begin
                  hit_in     = 1'b1;
                  slot_in    = rd_tag_ff;
                  hit_age_in = age_rd;
               end
               if (age_rd == AGE_MAX) begin
                  victim_in = rd_tag_ff;
               end
            end
            if (!issue && !rd_vld_ff) begin
               rd_idx_in = '0;
               evict_in  = !hit_ff && full;
               if (!hit_ff) begin
                  slot_in = full ? victim_ff : count_ff[IDX_W-1:0];
               end
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (issue) begin
               rd_en     = 1'b1;
               rd_idx_in = rd_idx_ff + 1'b1;
               rd_vld_in = 1'b1;
               rd_tag_in = rd_addr;
            end
            // write back one slot behind the read, so addresses never meet
            if (rd_vld_ff) begin
               age_wr_en = 1'b1;
               if (rd_tag_ff == slot_ff) begin
                  age_wr_data = '0;
               end else if (!hit_ff || age_rd < hit_age_ff) begin
                  age_wr_data = age_rd + 1'b1;
               end else begin
                  age_wr_data = age_rd;
               end
            end
            if (!issue && !rd_vld_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_ready) begin
               done        = 1'b1;
               key_wr_en   = !hit_ff;
               age_wr_en   = 1'b1;
               age_wr_addr = slot_ff;
               age_wr_data = '0;
               count_in    = count_next;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rd_vld_ff <= rd_vld_in;
      end
      key_ff     <= key_in;
      rd_idx_ff  <= rd_idx_in;
      rd_tag_ff  <= rd_tag_in;
      hit_ff     <= hit_in;
      evict_ff   <= evict_in;
      slot_ff    <= slot_in;
      victim_ff  <= victim_in;
      hit_age_ff <= hit_age_in;
   end

   assign idle = (state_ff == ST_IDLE);

   assign result.was_hit        = hit_ff;
   assign result.slot_index     = SLOT_W'(slot_ff);
   assign result.evicted_old    = evict_ff;
   assign result.occupied_count = OCC_W'(count_next);

endmodule

// ----- rtl/lru_lookup_or_insert_cache_top.sv -----
// fully associative lookup-or-insert cache with least-recently-used replacement.
// each request item carries one key; the response item says whether the key was
// already present, the slot that now holds it, whether a valid entry was evicted
// and how many entries are occupied afterwards. keys live in one synchronous ram
// and recency ages in a second one. entries fill from slot 0 upwards and are
// never freed, so an occupancy count stands in for per-entry valid bits and no
// clearing pass is needed after reset. one item is handled at a time: after
// acceptance an item goes through a compare scan over the occupied entries of
// the key and age rams, then a read-modify-write pass over the age ram, then
// the insert, which waits until the response register can take the result;
// the next item can be accepted in the cycle after the response is loaded.
// a new item is accepted as soon as the sequencer is idle,
// even while the previous response still waits in the output register.
// depends on lruc_pkg, lruc_if, lruc_ram and lruc_engine
module lru_lookup_or_insert_cache_top import lruc_pkg::*; #(
   parameter int ENTRIES  = DEF_ENTRIES,
   parameter int KEY_BITS = DEF_KEY_BITS
) (
   input  logic         clock,
   input  logic         reset,
   lruc_req_if.sink     req_ch,
   lruc_rsp_if.source   rsp_ch
);

   logic       eng_idle;
   logic       eng_done;
   logic       eng_start;
   logic       out_ready;
   result_type eng_result;

   // response holding register
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, rsp_data_in;

   // take an item whenever the sequencer is free
   assign req_ch.ready = eng_idle;
   assign eng_start    = req_ch.valid && eng_idle;

   // the sequencer may finish only when the response register can take the result
   assign out_ready = !rsp_valid_ff || rsp_ch.ready;

   lruc_engine #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (eng_start),
      .start_key (req_ch.lookup_key[KEY_BITS-1:0]),  // upper key bits are ignored
      .out_ready (out_ready),
      .idle      (eng_idle),
      .done      (eng_done),
      .result    (eng_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (eng_done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = eng_result;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.was_hit        = rsp_data_ff.was_hit;
   assign rsp_ch.slot_index     = rsp_data_ff.slot_index;
   assign rsp_ch.evicted_old    = rsp_data_ff.evicted_old;
   assign rsp_ch.occupied_count = rsp_data_ff.occupied_count;

endmodule
